[sv/blhs_pkg.sv]
`timescale 1ns / 1ps

package blhs_pkg;

  localparam int unsigned FW_W   = 11;
  localparam int unsigned FH_W   = 13;
  localparam int unsigned CFG_DW = 13;
  localparam int unsigned OY_W   = 12;
  localparam int unsigned PC_W   = 12;
  localparam int unsigned SUM_W  = 12;
  localparam int unsigned PROD_W = 24;
  localparam int unsigned LOW_LSB = 15;

  localparam logic [FW_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [7:0] BORDER = 8'd128;
  localparam logic [SUM_W-1:0] RECIP9 = 12'd3641;

  // Channel 0 is blue, 1 is green, 2 is red.
  typedef logic [2:0][7:0] pix_t;

  localparam pix_t PIX_BORDER = {BORDER, BORDER, BORDER};

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } lb_word_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic ofirst;
    logic top;
    logic bottom;
    logic left;
    logic right;
  } tag_t;

  typedef struct packed {
    pix_t low;
    pix_t high;
    pix_t delta;
    logic frame_end;
  } res_t;

endpackage

[sv/box_lowpass_highpass_split_unit.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Beat contents
// in_      in   in_valid/in_ready    pixel_blue, pixel_green, pixel_red, drain
// out_     out  out_valid/out_ready  low_*, high_*, delta_*, frame_end
// cfg_     in   cfg_we               cfg_index, cfg_data
//
// One input beat per cycle while in_ready is high; a result passes through stages 1 to 4 and the output queue.
// Every beat reads and rewrites one line buffer entry through a registered memory port.
// A two-entry output queue lets input continue while one result waits; in_ready
// drops only when both entries are full.
// Reset is synchronous; the line buffers are not cleared.

module box_lowpass_highpass_split_unit import blhs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_pixel_blue,
  input  logic [7:0]         in_pixel_green,
  input  logic [7:0]         in_pixel_red,
  input  logic               in_drain,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_low_blue,
  output logic [7:0]         out_low_green,
  output logic [7:0]         out_low_red,
  output logic signed [7:0]  out_high_blue,
  output logic signed [7:0]  out_high_green,
  output logic signed [7:0]  out_high_red,
  output logic signed [7:0]  out_delta_blue,
  output logic signed [7:0]  out_delta_green,
  output logic signed [7:0]  out_delta_red,
  output logic               out_frame_end,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned CXW = (AW > FW_W) ? AW : FW_W;
  localparam logic [FH_W-1:0] MAXW = FH_W'(MAX_WIDTH);

  function automatic logic [7:0] sat8(input logic signed [8:0] v);
    logic [7:0] res;
    if (v < -9'sd128) begin
      res = 8'h80;
    end else if (v > 9'sd127) begin
      res = 8'h7F;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic [FW_W-1:0] eff_w;
  logic [FH_W-1:0] eff_h;

  logic [AW-1:0]   col_r;
  logic [PC_W-1:0] pcnt_r;
  logic [AW-1:0]   ox_r;
  logic [OY_W-1:0] oy_r;

  logic  advance;
  logic  accept;
  pix_t  px_in;
  logic  col_last;
  logic  ox_last;
  logic  oy_last;
  tag_t  tag_in;

  logic          s1_valid_r;
  pix_t          s1_px_r;
  logic [AW-1:0] s1_col_r;
  logic          s1_first_r;
  tag_t          s1_tag_r;

  lb_word_t lb_rd;
  lb_word_t lb_wr;
  pix_t     win_r   [9];
  pix_t     win_nxt [9];
  pix_t     win_base[9];

  logic                  s2_valid_r;
  tag_t                  s2_tag_r;
  logic [2:0][SUM_W-1:0] sum_nxt;

  logic                  s3_valid_r;
  tag_t                  s3_tag_r;
  logic [2:0][SUM_W-1:0] sum_r;
  pix_t                  s3_center_r;

  logic                   s4_valid_r;
  tag_t                   s4_tag_r;
  pix_t                   low_r;
  pix_t                   s4_center_r;
  logic [2:0][PROD_W-1:0] prod;
  pix_t                   low_nxt;

  pix_t prev_low_r;
  pix_t prev_sel;
  res_t res_nxt;

  res_t       q_r [2];
  logic [1:0] q_cnt_r;
  logic       push;
  logic       pop;

  // Effective frame size.
  always_comb begin
    if (fw_r == '0) begin
      eff_w = FW_W'(1);
    end else if ({2'b00, fw_r} > MAXW) begin
      eff_w = FW_W'(MAXW);
    end else begin
      eff_w = fw_r;
    end
    if (fh_r == '0) begin
      eff_h = FH_W'(1);
    end else if (fh_r > MAX_HEIGHT) begin
      eff_h = MAX_HEIGHT;
    end else begin
      eff_h = fh_r;
    end
  end

  assign advance  = (q_cnt_r != 2'd2);
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  assign px_in    = in_drain ? PIX_BORDER : {in_pixel_red, in_pixel_green, in_pixel_blue};
  assign col_last = (CXW'(col_r) == CXW'(eff_w - FW_W'(1)));
  assign ox_last  = (CXW'(ox_r) == CXW'(eff_w - FW_W'(1)));
  assign oy_last  = (({1'b0, oy_r} + FH_W'(1)) == eff_h);

  always_comb begin
    tag_in.emit   = (pcnt_r == (PC_W'(eff_w) + PC_W'(1)));
    tag_in.top    = (oy_r == '0);
    tag_in.bottom = oy_last;
    tag_in.left   = (ox_r == '0);
    tag_in.right  = ox_last;
    tag_in.ofirst = tag_in.top && tag_in.left;
    tag_in.last   = tag_in.emit && ox_last && oy_last;
  end

  // Configuration and input position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= RST_WIDTH;
      fh_r   <= RST_HEIGHT;
      col_r  <= '0;
      pcnt_r <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH: begin
          fw_r <= cfg_data[FW_W-1:0];
        end
        CFG_IDX_HEIGHT: begin
          fh_r <= cfg_data[FH_W-1:0];
        end
        default: begin
          fw_r <= fw_r;
        end
      endcase
      col_r  <= '0;
      pcnt_r <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
    end else if (accept) begin
      if (tag_in.last) begin
        col_r  <= '0;
        pcnt_r <= '0;
        ox_r   <= '0;
        oy_r   <= '0;
      end else begin
        col_r <= col_last ? '0 : col_r + AW'(1);
        if (!tag_in.emit) begin
          pcnt_r <= pcnt_r + PC_W'(1);
        end else if (ox_last) begin
          ox_r <= '0;
          oy_r <= oy_r + OY_W'(1);
        end else begin
          ox_r <= ox_r + AW'(1);
        end
      end
    end
  end

  // Stage 1: line buffer word is read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r    <= px_in;
      s1_col_r   <= col_r;
      s1_first_r <= (pcnt_r == '0);
      s1_tag_r   <= tag_in;
    end
  end

  assign lb_wr.upper  = lb_rd.middle;
  assign lb_wr.middle = s1_px_r;

  blhs_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (lb_rd),
    .wr_en   (s1_valid_r && advance),
    .wr_addr (s1_col_r),
    .wr_data (lb_wr)
  );

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_base[i] = s1_first_r ? PIX_BORDER : win_r[i];
    end
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_base[r*3+1];
      win_nxt[r*3+1] = win_base[r*3+2];
    end
    win_nxt[2] = lb_rd.upper;
    win_nxt[5] = lb_rd.middle;
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
      s2_tag_r <= s1_tag_r;
    end
  end

  // Stage 2: window sums with the border rule.
  always_comb begin
    logic [SUM_W-1:0] acc;
    logic [7:0]       v;
    logic             outside;
    for (int ch = 0; ch < 3; ch++) begin
      acc = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          outside = ((r == 0) && s2_tag_r.top) || ((r == 2) && s2_tag_r.bottom) ||
                    ((c == 0) && s2_tag_r.left) || ((c == 2) && s2_tag_r.right);
          v = outside ? BORDER : win_r[r*3+c][ch];
          acc = acc + SUM_W'(v);
        end
      end
      sum_nxt[ch] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r && s1_tag_r.emit;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && advance) begin
      sum_r       <= sum_nxt;
      s3_center_r <= win_r[4];
      s3_tag_r    <= s2_tag_r;
    end
  end

  // Stage 3: divide by nine through the reciprocal.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]    = PROD_W'(sum_r[ch]) * PROD_W'(RECIP9);
      low_nxt[ch] = prod[ch][LOW_LSB+7:LOW_LSB];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r && advance) begin
      low_r       <= low_nxt;
      s4_center_r <= s3_center_r;
      s4_tag_r    <= s3_tag_r;
    end
  end

  // Stage 4: high band and delta.
  assign prev_sel = s4_tag_r.ofirst ? PIX_BORDER : prev_low_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      res_nxt.low[ch]   = low_r[ch];
      res_nxt.high[ch]  = sat8($signed({1'b0, s4_center_r[ch]}) - $signed({1'b0, low_r[ch]}));
      res_nxt.delta[ch] = sat8($signed({1'b0, low_r[ch]}) - $signed({1'b0, prev_sel[ch]}));
    end
    res_nxt.frame_end = s4_tag_r.last;
  end

  assign push = s4_valid_r && advance;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      prev_low_r <= low_r;
    end
  end

  // Output queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (q_cnt_r == 2'd2)) begin
      q_r[0] <= q_r[1];
    end
    if (push) begin
      if ((q_cnt_r == 2'd0) || ((q_cnt_r == 2'd1) && pop)) begin
        q_r[0] <= res_nxt;
      end else begin
        q_r[1] <= res_nxt;
      end
    end
  end

  assign out_valid       = (q_cnt_r != 2'd0);
  assign out_low_blue    = q_r[0].low[0];
  assign out_low_green   = q_r[0].low[1];
  assign out_low_red     = q_r[0].low[2];
  assign out_high_blue   = signed'(q_r[0].high[0]);
  assign out_high_green  = signed'(q_r[0].high[1]);
  assign out_high_red    = signed'(q_r[0].high[2]);
  assign out_delta_blue  = signed'(q_r[0].delta[0]);
  assign out_delta_green = signed'(q_r[0].delta[1]);
  assign out_delta_red   = signed'(q_r[0].delta[2]);
  assign out_frame_end   = q_r[0].frame_end;

endmodule

[sv/blhs_linebuf.sv]
`timescale 1ns / 1ps

module blhs_linebuf import blhs_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output lb_word_t      rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  lb_word_t      wr_data
);

  lb_word_t mem_r [DEPTH];
  lb_word_t rd_data_r;
  lb_word_t fwd_data_r;
  logic     fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem_r[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // A read that meets a write to the same entry takes the new word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_data_r;

endmodule

[sv/blhs_checker.sv]
`timescale 1ns / 1ps

module blhs_checker import blhs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        out_low_blue,
  input logic signed [7:0] out_high_blue,
  input logic signed [7:0] out_delta_blue,
  input logic              out_frame_end
);

  // A waiting result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low_blue) &&
      $stable(out_high_blue) && $stable(out_delta_blue) && $stable(out_frame_end))
    else $error("result beat changed while stalled");

  // Input is only held off while results are pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_stall_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stall began without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind box_lowpass_highpass_split_unit blhs_checker u_blhs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_low_blue   (out_low_blue),
  .out_high_blue  (out_high_blue),
  .out_delta_blue (out_delta_blue),
  .out_frame_end  (out_frame_end)
);
